FILE: rtl/sipq_pkg.sv
package sipq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PRI_W = 8;
    localparam int PAY_W = 32;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [PAY_W-1:0] pay;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t ent;
    } cmd_t;

endpackage

FILE: rtl/sipq_cell.sv
module sipq_cell (
    input  logic            aclk,
    input  sipq_pkg::cmd_t  cmd_i,
    input  logic            occ_i,
    input  logic            prev_keep_i,
    input  sipq_pkg::entry_t prev_entry_i,
    input  sipq_pkg::entry_t next_entry_i,
    output sipq_pkg::entry_t entry_o,
    output logic            keep_o
);
    import sipq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // cell holds its entry on enqueue when it is occupied and not lower than the new one
    assign keep_o  = occ_i && (entry_reg.pri >= cmd_i.ent.pri);
    assign entry_o = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd_i.enq) begin
            if (!keep_o) begin
                entry_next = prev_keep_i ? cmd_i.ent : prev_entry_i;
            end
        end else if (cmd_i.deq) begin
            entry_next = next_entry_i;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/sorted_insert_priority_queue_core.sv
// the result is registered and appears on the master side in the cycle after acceptance
// throughput: one item per cycle unless the master side stalls; every cell of the chain updates
// in one step on each enqueue or dequeue, and the output register frees when its item is taken
// reset: aresetn synchronous active low clears the fill count and the output valid,
// so the queue starts empty; cell contents are not reset
module sorted_insert_priority_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // priority_req[7:0], payload[39:8]
    input  logic        s_tuser,  // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // ok, out_priority[8:1], out_payload[40:9], is_empty, is_full
);
    import sipq_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [47:0]      m_tdata_reg;
    logic [47:0]      m_tdata_next;

    logic             accept;
    logic             q_empty;
    logic             q_full;
    logic             do_ok;
    cmd_t             cmd;
    entry_t           in_entry;
    entry_t           out_entry;
    entry_t           cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_keep;
    logic [DEPTH-1:0] cell_occ;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));

    assign in_entry.pri = s_tdata[7:0];
    assign in_entry.pay = s_tdata[39:8];

    assign cmd.enq = accept && (s_tuser == OP_ENQ) && !q_full;
    assign cmd.deq = accept && (s_tuser == OP_DEQ) && !q_empty;
    assign cmd.ent = in_entry;

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            cell_occ[k] = (CNT_W'(k) < count_reg);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic   prev_keep;
            entry_t prev_entry;
            entry_t next_entry;
            if (g == 0) begin : g_head
                assign prev_keep  = 1'b1;
                assign prev_entry = in_entry;
            end else begin : g_body
                assign prev_keep  = cell_keep[g-1];
                assign prev_entry = cell_entry[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign next_entry = '0;
            end else begin : g_mid
                assign next_entry = cell_entry[g+1];
            end
            sipq_cell u_cell (
                .aclk         (aclk),
                .cmd_i        (cmd),
                .occ_i        (cell_occ[g]),
                .prev_keep_i  (prev_keep),
                .prev_entry_i (prev_entry),
                .next_entry_i (next_entry),
                .entry_o      (cell_entry[g]),
                .keep_o       (cell_keep[g])
            );
        end
    endgenerate

    always_comb begin
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        do_ok         = cmd.enq || cmd.deq;
        out_entry     = cmd.deq ? cell_entry[0] : '0;
        if (cmd.enq) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.deq) begin
            count_next = count_reg - CNT_W'(1);
        end
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (accept) begin
            m_tvalid_next      = 1'b1;
            m_tdata_next       = '0;
            m_tdata_next[0]    = do_ok;
            m_tdata_next[8:1]  = out_entry.pri;
            m_tdata_next[40:9] = out_entry.pay;
            m_tdata_next[41]   = (count_next == '0);
            m_tdata_next[42]   = (count_next == CNT_W'(DEPTH));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sipq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int CALM_TAIL = 80;

    typedef struct {
        logic              drain;
        logic              op;
        logic [PRI_W-1:0]  pri;
        logic [PAY_W-1:0]  pay;
    } request_t;

    typedef struct {
        logic              ok;
        logic [PRI_W-1:0]  pri;
        logic [PAY_W-1:0]  pay;
        logic              empty;
        logic              full;
    } outcome_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // priority_req[7:0], payload[39:8]
    logic        s_tuser = 1'b0; // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // ok, out_priority[8:1], out_payload[40:9], is_empty, is_full

    request_t pending_reqs[$];
    outcome_t awaited_results[$];
    entry_t   model_queue[$];
    request_t cur_req;
    int       sent_count = 0;
    int       gap_left = 0;
    int       stall_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       error_count = 0;
    int       cycle_count = 0;

    sorted_insert_priority_queue_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        entry_t   e;
        int       pos;
        o = '{default: '0};
        if (r.op == OP_ENQ) begin
            if (model_queue.size() < DEPTH) begin
                pos = model_queue.size();
                while (pos > 0 && model_queue[pos-1].pri < r.pri) pos--;
                e.pri = r.pri;
                e.pay = r.pay;
                model_queue.insert(pos, e);
                o.ok = 1'b1;
            end
        end else if (model_queue.size() > 0) begin
            e = model_queue.pop_front();
            o.ok = 1'b1;
            o.pri = e.pri;
            o.pay = e.pay;
        end
        o.empty = (model_queue.size() == 0);
        o.full = (model_queue.size() == DEPTH);
        return o;
    endfunction

    task automatic push_req(logic op, logic [PRI_W-1:0] pri, logic [PAY_W-1:0] pay);
        request_t r;
        r.drain = 1'b0;
        r.op = op;
        r.pri = pri;
        r.pay = pay;
        pending_reqs.push_back(r);
    endtask

    task automatic push_drain();
        request_t r;
        r = '{drain: 1'b1, op: OP_ENQ, pri: '0, pay: '0};
        pending_reqs.push_back(r);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                awaited_results.push_back(apply_request(cur_req));
                sent_count++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_reqs[0].drain) begin
                    s_tvalid <= 1'b0;
                    if (awaited_results.size() == 0) void'(pending_reqs.pop_front());
                end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    s_tvalid <= 1'b0;
                end else begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_req.pay, cur_req.pri};
                    s_tuser <= cur_req.op;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        outcome_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    $error("unexpected item on result channel: %h", m_tdata);
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[0] !== want.ok) begin
                        $error("ok: expected %0d, actual %0d", want.ok, m_tdata[0]);
                        error_count++;
                    end
                    if (m_tdata[8:1] !== want.pri) begin
                        $error("out_priority: expected %0d, actual %0d", want.pri, m_tdata[8:1]);
                        error_count++;
                    end
                    if (m_tdata[40:9] !== want.pay) begin
                        $error("out_payload: expected %h, actual %h", want.pay, m_tdata[40:9]);
                        error_count++;
                    end
                    if (m_tdata[41] !== want.empty) begin
                        $error("is_empty: expected %0d, actual %0d", want.empty, m_tdata[41]);
                        error_count++;
                    end
                    if (m_tdata[42] !== want.full) begin
                        $error("is_full: expected %0d, actual %0d", want.full, m_tdata[42]);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && sent_count >= 200) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sorted_insert_priority_queue_core");
            $finish;
        end
    end

    initial begin
        int               n;
        int               len;
        int               enq_pct;
        bit               narrow;
        bit               drained;
        logic             op;
        logic [PRI_W-1:0] pri;

        // directed: empty dequeue, extremes, ties, fill, full drop
        push_req(OP_DEQ, 8'd0, 32'd0);
        push_req(OP_ENQ, 8'd0, 32'h0000_0000);
        push_req(OP_ENQ, 8'd255, 32'hffff_ffff);
        push_req(OP_ENQ, 8'd128, 32'ha5a5_a5a5);
        push_req(OP_ENQ, 8'd128, 32'h5a5a_5a5a);
        push_req(OP_ENQ, 8'd128, 32'h0000_0001);
        for (int i = 0; i < DEPTH - 5; i++) push_req(OP_ENQ, 8'(i * 23 + 1), 32'(1) << (i * 3));
        push_req(OP_ENQ, 8'd255, 32'hdead_beef);
        push_req(OP_DEQ, 8'd255, 32'hffff_ffff);
        push_req(OP_DEQ, 8'd0, 32'd0);
        push_req(OP_DEQ, 8'd0, 32'd0);
        push_drain();

        // random: phases biased toward filling or emptying, or balanced
        n = 0;
        drained = 1'b0;
        while (n < 700) begin
            case ($urandom_range(0, 2))
                0: enq_pct = 25;
                1: enq_pct = 50;
                default: enq_pct = 80;
            endcase
            narrow = $urandom_range(0, 1);
            len = $urandom_range(10, 40);
            for (int k = 0; k < len; k++) begin
                op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
                case ($urandom_range(0, 9))
                    0: pri = 8'd0;
                    1: pri = 8'd255;
                    default: pri = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
                endcase
                push_req(op, pri, $urandom);
                n++;
            end
            if (n >= 350 && !drained) begin
                push_drain();
                drained = 1'b1;
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() > 0 || s_tvalid || awaited_results.size() > 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS sorted_insert_priority_queue_core");
        end else begin
            $display("FAIL sorted_insert_priority_queue_core");
        end
        $finish;
    end

endmodule
